/* sv/random_sample_set_defines.svh */
// ----------------------------------------------------------------------------
// Random sample set assertion macros
// Shared property forms for the port-level checks of the set block.
// ----------------------------------------------------------------------------
`ifndef RANDOM_SAMPLE_SET_DEFINES_SVH
`define RANDOM_SAMPLE_SET_DEFINES_SVH

// The condition holds in the same cycle as the trigger.
`define RSS_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("random_sample_set: property failed");

// The condition holds in the cycle after the trigger.
`define RSS_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("random_sample_set: property failed");

`endif

/* sv/rss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random sample set package
// Field widths, operation and status codes, and the control interface types.
// ----------------------------------------------------------------------------
package rss_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int OP_W   = 2;
   localparam int VAL_W  = 32;
   localparam int RW_W   = 16;
   localparam int ST_W   = 2;
   localparam int SIZE_W = 5;
   localparam int BIT_W  = $clog2(RW_W);
   localparam int REQ_W  = ((VAL_W + RW_W + 7) / 8) * 8;
   localparam int RSP_W  = ((VAL_W + SIZE_W + 7) / 8) * 8;
   localparam int RSP_PAD = RSP_W - VAL_W - SIZE_W;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_RANDOM = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_DONE     = 2'd0,
      ST_PRESENCE = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SEARCH,
      S_MOVE_RD,
      S_MOVE_WR,
      S_DIV,
      S_RND_RD,
      S_FINISH
   } state_type;

   typedef enum logic {
      RD_LAST,
      RD_RAND
   } rd_sel_type;

   typedef enum logic {
      WR_APPEND,
      WR_MOVE
   } wr_sel_type;

   typedef struct packed {
      logic       load;
      logic       search_run;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       div_start;
      logic       out_load;
      status_type out_status;
      logic       out_mem;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   search_done;
      logic   found;
      logic   pos_last;
      logic   full;
      logic   empty;
      logic   div_done;
      logic   out_free;
   } dp_stat_type;

endpackage

/* sv/rss_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random sample set modulo unit
// Restoring remainder of the random word by the live count, one bit a cycle.
// ----------------------------------------------------------------------------
module rss_mod
   import rss_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [RW_W-1:0]              dividend,
   input  logic [$clog2(CAPACITY+1)-1:0] divisor,
   output logic                         done,
   output logic [$clog2(CAPACITY)-1:0]  remainder
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [BIT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [RW_W-1:0]  sh_ff, sh_in;
   logic [CNT_W:0]   trial;
   logic [CNT_W:0]   diff;

   assign trial = {rem_ff, sh_ff[RW_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         sh_in   = dividend;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so one subtract suffices.
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[CNT_W-1:0];
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         sh_in  = {sh_ff[RW_W-2:0], 1'b0};
         cnt_in = cnt_ff + BIT_W'(1);
         if (cnt_ff == BIT_W'(RW_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[IDX_W-1:0];

endmodule

/* sv/rss_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random sample set controller
// Sequences search, move, modulo and result hand-off for one item at a time.
// ----------------------------------------------------------------------------
module rss_ctrl
   import rss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type  state_ff, state_in;
   status_type code_ff, code_in;
   logic       sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      sel_ff  <= sel_in;
   end

   always_comb begin
      state_in   = state_ff;
      code_in    = code_ff;
      sel_in     = sel_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            code_in = ST_DONE;
            sel_in  = 1'b0;
            case (stat.op)
               OP_INSERT, OP_REMOVE: begin
                  state_in = S_SEARCH;
               end
               OP_RANDOM: begin
                  if (stat.empty) begin
                     code_in  = ST_EMPTY;
                     state_in = S_FINISH;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SEARCH: begin
            cmd.search_run = 1'b1;
            if (stat.search_done) begin
               state_in = S_FINISH;
               if (stat.op == OP_INSERT) begin
                  // A present value is reported before a full set.
                  if (stat.found) begin
                     code_in = ST_PRESENCE;
                  end else if (stat.full) begin
                     code_in = ST_FULL;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = WR_APPEND;
                     cmd.cnt_inc = 1'b1;
                  end
               end else begin
                  if (!stat.found) begin
                     code_in = ST_PRESENCE;
                  end else if (stat.pos_last) begin
                     cmd.cnt_dec = 1'b1;
                  end else begin
                     state_in = S_MOVE_RD;
                  end
               end
            end
         end
         S_MOVE_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LAST;
            state_in   = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_MOVE;
            cmd.cnt_dec = 1'b1;
            state_in    = S_FINISH;
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_RND_RD;
            end
         end
         S_RND_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_RAND;
            sel_in     = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = code_ff;
               cmd.out_mem    = sel_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* sv/rss_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random sample set datapath
// Member memory, count, sequential membership scan, modulo unit, result register.
// ----------------------------------------------------------------------------
module rss_datapath
   import rss_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic [OP_W-1:0]  req_tuser,
   input  ctrl_cmd_type     cmd,
   output dp_stat_type      stat,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic [ST_W-1:0]  rsp_tuser
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [VAL_W-1:0]  mem [CAPACITY];

   op_type            op_ff;
   logic [VAL_W-1:0]  value_ff;
   logic [RW_W-1:0]   rword_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  rd_idx_ff;
   logic              cmp_vld_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  pos_ff;
   logic [VAL_W-1:0]  rdata_ff;
   logic              rsp_vld_ff;
   status_type        status_ff;
   logic [VAL_W-1:0]  member_ff;
   logic [SIZE_W-1:0] size_ff;

   logic              match_now;
   logic              scan_issue;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic [CNT_W-1:0]  cnt_last;
   logic [IDX_W-1:0]  rand_idx;
   logic              div_done;

   assign cnt_last   = count_ff - CNT_W'(1);
   assign match_now  = cmp_vld_ff && (rdata_ff == value_ff);
   assign scan_issue = cmd.search_run && !found_ff && !match_now && (rd_idx_ff < count_ff);
   assign rd_en      = scan_issue || cmd.rd_en;

   always_comb begin
      if (scan_issue) begin
         rd_addr = rd_idx_ff[IDX_W-1:0];
      end else if (cmd.rd_sel == RD_LAST) begin
         rd_addr = cnt_last[IDX_W-1:0];
      end else begin
         rd_addr = rand_idx;
      end
   end

   assign wr_addr = (cmd.wr_sel == WR_APPEND) ? count_ff[IDX_W-1:0] : pos_ff;
   assign wr_data = (cmd.wr_sel == WR_APPEND) ? value_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   rss_mod #(
      .CAPACITY (CAPACITY)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rword_ff),
      .divisor   (count_ff),
      .done      (div_done),
      .remainder (rand_idx)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_tuser);
         value_ff <= req_tdata[VAL_W-1:0];
         rword_ff <= req_tdata[VAL_W +: RW_W];
      end
      if (scan_issue) begin
         cmp_idx_ff <= rd_idx_ff[IDX_W-1:0];
      end
      if (match_now) begin
         pos_ff <= cmp_idx_ff;
      end
      if (cmd.out_load) begin
         status_ff <= cmd.out_status;
         member_ff <= cmd.out_mem ? rdata_ff : '0;
         size_ff   <= SIZE_W'(count_ff);
      end
   end

   // The scan reads one entry a cycle and compares it in the following cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rd_idx_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (cmd.cnt_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= cnt_last;
         end
         if (cmd.load) begin
            rd_idx_ff  <= '0;
            cmp_vld_ff <= 1'b0;
            found_ff   <= 1'b0;
         end else begin
            cmp_vld_ff <= scan_issue;
            if (scan_issue) begin
               rd_idx_ff <= rd_idx_ff + CNT_W'(1);
            end
            if (match_now) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      stat.op          = op_ff;
      stat.search_done = found_ff || (!cmp_vld_ff && (rd_idx_ff == count_ff));
      stat.found       = found_ff;
      stat.pos_last    = (CNT_W'(pos_ff) == cnt_last);
      stat.full        = (count_ff == CNT_W'(CAPACITY));
      stat.empty       = (count_ff == '0);
      stat.div_done    = div_done;
      stat.out_free    = !rsp_vld_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, size_ff, member_ff};
   assign rsp_tuser  = status_ff;

endmodule

/* sv/random_sample_set.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random sample set
// Set of distinct 32-bit values with insert, remove and random-member requests.
// ----------------------------------------------------------------------------
// Requests enter on the req_ stream: req_tuser carries the operation, req_tdata
// the value and the random word. Each request yields exactly one item on the
// rsp_ stream with the status in rsp_tuser and the chosen member and the new
// set size in rsp_tdata.
// One request is in flight at a time. Insert and remove scan the live entries
// through the single read port of the member memory, one entry a cycle. A
// random request runs a bit-serial modulo over the 16-bit random word and then
// reads one entry. req_tready returns as rsp_tvalid rises.
// Reset empties the set at once; the memory itself is not cleared, since only
// entries below the count are ever read.
// A finished item waits in the output register while rsp_tready is low; the
// block then takes the next request but holds its result until the output
// register drains.
// ----------------------------------------------------------------------------
module random_sample_set
   import rss_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // value [31:0], random_word [47:32]
   input  logic [OP_W-1:0]  req_tuser,   // operation [1:0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // member [31:0], size_now [36:32], zeros above
   output logic [ST_W-1:0]  rsp_tuser    // status [1:0]
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   rss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rss_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* sv/rss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random sample set port checker
// Port-level checks of the set block, attached to every instance by bind.
// ----------------------------------------------------------------------------
`include "random_sample_set_defines.svh"

module rss_checker
   import rss_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic [ST_W-1:0]  rsp_tuser
);

   // A stalled result item keeps its contents.
   `RSS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Only one request is worked on at a time.
   `RSS_ASSERT_NXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // A full set reports its capacity as the size.
   `RSS_ASSERT_IMP(a_full_size, clock, reset, rsp_tvalid && (rsp_tuser == ST_FULL), rsp_tdata[VAL_W +: SIZE_W] == SIZE_W'(CAPACITY))

   // An empty set gives no member and a size of zero.
   `RSS_ASSERT_IMP(a_empty_zero, clock, reset, rsp_tvalid && (rsp_tuser == ST_EMPTY), rsp_tdata == '0)

endmodule

bind random_sample_set rss_checker #(.CAPACITY(CAPACITY)) u_rss_checker (.*);
